// ===== src/multiplexed_servo_pwm_core_assert.svh =====
// Assertion macros shared by the servo core files.
// IMP: antecedent implies consequent in the same cycle.
// NXT: antecedent implies consequent in the next cycle.
`ifndef MULTIPLEXED_SERVO_PWM_CORE_ASSERT_SVH
`define MULTIPLEXED_SERVO_PWM_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MSP_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSP_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSP_ASSERT_IMP(name, clk, rstn, ante, cons)
`define MSP_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== src/msp_pkg.sv =====
`timescale 1ns / 1ps

package msp_pkg;

    localparam int CHANNELS = 8;
    localparam int W        = 16;
    localparam int CH_W     = 3;
    localparam int CNT_W    = 4;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WIDTH = 2'd1;
    localparam logic [1:0] REQ_ANGLE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_REVERSE_MASK  = 3'd1;
    localparam logic [2:0] REG_SLOT_TICKS    = 3'd2;
    localparam logic [2:0] REG_MIN_WIDTH     = 3'd3;
    localparam logic [2:0] REG_MAX_WIDTH     = 3'd4;
    localparam logic [2:0] REG_CENTER_WIDTH  = 3'd5;
    localparam logic [2:0] REG_MIN_ANGLE     = 3'd6;
    localparam logic [2:0] REG_MAX_ANGLE     = 3'd7;

    localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
    localparam logic [7:0]       RST_REVERSE_MASK  = 8'd0;
    localparam logic [W-1:0]     RST_SLOT_TICKS    = 16'd3000;
    localparam logic [W-1:0]     RST_MIN_WIDTH     = 16'd600;
    localparam logic [W-1:0]     RST_MAX_WIDTH     = 16'd2400;
    localparam logic [W-1:0]     RST_CENTER_WIDTH  = 16'd1500;
    localparam logic [W-1:0]     RST_MIN_ANGLE     = 16'hFFA6;
    localparam logic [W-1:0]     RST_MAX_ANGLE     = 16'd90;

    typedef struct packed {
        logic               start;
        logic signed [W-1:0] angle;
    } ang_req_t;

    typedef struct packed {
        logic signed [W-1:0] min_angle;
        logic signed [W-1:0] max_angle;
        logic [W-1:0]        min_width;
        logic [W-1:0]        max_width;
        logic [W-1:0]        center_width;
    } ang_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ang_stat_t;

    // Reverse unless the channel's bit is set, then clamp to min..max (max wins).
    function automatic logic [W-1:0] clamp_width(
        input logic [W-1:0] t,
        input logic         rev,
        input logic [W-1:0] minw,
        input logic [W-1:0] maxw
    );
        logic [W-1:0] nt;
        nt = rev ? t : (maxw + minw - t);
        if (nt < minw) nt = minw;
        if (nt > maxw) nt = maxw;
        return nt;
    endfunction

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cc);
        logic [CNT_W-1:0] n;
        n = cc;
        if (n == '0) n = CNT_W'(1);
        if (n > CNT_W'(CHANNELS)) n = CNT_W'(CHANNELS);
        return n;
    endfunction

    localparam logic [W-1:0] RST_COMPARE =
        clamp_width(RST_CENTER_WIDTH, 1'b0, RST_MIN_WIDTH, RST_MAX_WIDTH);

endpackage

// ===== src/msp_angle_div.sv =====
`timescale 1ns / 1ps
`include "multiplexed_servo_pwm_core_assert.svh"

module msp_angle_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msp_pkg::ang_req_t    req,
    input  msp_pkg::ang_cfg_t    cfg,
    output msp_pkg::ang_stat_t   stat,
    output logic [msp_pkg::W-1:0] width
);

    localparam int W     = msp_pkg::W;
    localparam int CNT_W = $clog2(2 * W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(2 * W - 1);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_SIGN = 3'd1;
    localparam logic [2:0] U_MUL  = 3'd2;
    localparam logic [2:0] U_DIV  = 3'd3;
    localparam logic [2:0] U_FIN  = 3'd4;

    logic [2:0]       st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W:0]       span_reg, span_next;
    logic [W:0]       dw_reg, dw_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     mcand_reg, mcand_next;
    logic [2*W:0]     prod_reg, prod_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     res_reg, res_next;

    logic signed [W-1:0] a_lo, a_cl;
    logic [W:0]          span_in, dw_in;
    logic [W-1:0]        a_mag, dw_mag, span_mag;
    logic [W:0]          dw_neg, span_neg;
    logic [W:0]          add_sum;
    logic [W+1:0]        trial;
    logic [W-1:0]        q_signed;

    always_comb begin
        a_lo    = (req.angle < cfg.min_angle) ? cfg.min_angle : req.angle;
        a_cl    = (a_lo > cfg.max_angle) ? cfg.max_angle : a_lo;
        span_in = {cfg.max_angle[W-1], cfg.max_angle} - {cfg.min_angle[W-1], cfg.min_angle};
        dw_in   = {1'b0, cfg.max_width} - {1'b0, cfg.min_width};

        a_mag    = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
        dw_neg   = (W+1)'(0) - dw_reg;
        span_neg = (W+1)'(0) - span_reg;
        dw_mag   = dw_reg[W] ? dw_neg[W-1:0] : dw_reg[W-1:0];
        span_mag = span_reg[W] ? span_neg[W-1:0] : span_reg[W-1:0];

        // shift-add: add the multiplicand into the upper half when the low bit is set
        add_sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, mcand_reg} : (W+1)'(0));
        // restoring step: bring down one dividend bit and try the subtract
        trial   = {1'b0, rem_reg, prod_reg[2*W-1]} - {2'b00, dvs_reg};

        q_signed = zero_reg ? W'(0) : (neg_reg ? (W'(0) - quo_reg) : quo_reg);
    end

    always_comb begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        span_next  = span_reg;
        dw_next    = dw_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        dvs_next   = dvs_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        unique case (st_reg)
            U_IDLE: begin
                if (req.start) begin
                    a_next    = a_cl;
                    span_next = span_in;
                    dw_next   = dw_in;
                    st_next   = U_SIGN;
                end
            end
            U_SIGN: begin
                neg_next   = a_reg[W-1] ^ dw_reg[W] ^ span_reg[W];
                zero_next  = (span_reg == '0);
                dvs_next   = span_mag;
                mcand_next = dw_mag;
                prod_next  = {(W+1)'(0), a_mag};
                cnt_next   = '0;
                st_next    = U_MUL;
            end
            U_MUL: begin
                prod_next = {1'b0, add_sum, prod_reg[W-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST) begin
                    cnt_next = '0;
                    rem_next = '0;
                    st_next  = U_DIV;
                end
            end
            U_DIV: begin
                prod_next = {prod_reg[2*W-1:0], 1'b0};
                if (!trial[W+1]) begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[W-2:0], prod_reg[2*W-1]};
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    st_next = U_FIN;
                end
            end
            U_FIN: begin
                res_next = q_signed + cfg.center_width;
                st_next  = U_IDLE;
            end
            default: begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= U_IDLE;
            cnt_reg <= '0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        span_reg  <= span_next;
        dw_reg    <= dw_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        dvs_reg   <= dvs_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        res_reg   <= res_next;
    end

    assign stat.busy = (st_reg != U_IDLE);
    assign stat.done = (st_reg == U_FIN);
    assign width     = res_reg;

    `MSP_ASSERT_IMP(a_rem_below_divisor, aclk, aresetn, (st_reg == U_DIV) && (dvs_reg != '0), rem_reg < dvs_reg)
    `MSP_ASSERT_IMP(a_prod_top_clear, aclk, aresetn, st_reg == U_MUL, prod_reg[2*W] == 1'b0)
    `MSP_ASSERT_NXT(a_start_runs, aclk, aresetn, req.start && (st_reg == U_IDLE), st_reg == U_SIGN)

endmodule

// ===== src/multiplexed_servo_pwm_core.sv =====
`timescale 1ns / 1ps
`include "multiplexed_servo_pwm_core_assert.svh"
// Timer ticks, set-width and ignored requests give their word in the cycle after
//   acceptance; a set-angle request runs a bit-serial 16-step multiply and 32-step
//   restoring divide in msp_angle_div, setup and finish, then a write-back held until
//   the output is free. One request at a time; s_ready needs idle and a free output.
// Reset: synchronous, active low; registers return to their defaults and every compare
//   value to the neutral width, with no clearing pass.

module multiplexed_servo_pwm_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [2:0]         s_channel,
    input  logic [15:0]        s_pulse_width,
    input  logic signed [15:0] s_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pwm_levels,
    output logic [2:0]         m_active_channel,
    output logic [15:0]        m_slot_count
);

    localparam int W     = msp_pkg::W;
    localparam int CH_W  = msp_pkg::CH_W;
    localparam int CNT_W = msp_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ANGLE = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    // configuration
    logic [CNT_W-1:0] channel_count_reg;
    logic [7:0]       reverse_mask_reg;
    logic [W-1:0]     slot_ticks_reg;
    logic [W-1:0]     min_width_reg;
    logic [W-1:0]     max_width_reg;
    logic [W-1:0]     center_width_reg;
    logic [W-1:0]     min_angle_reg;
    logic [W-1:0]     max_angle_reg;

    logic [1:0]       state_reg, state_next;
    logic [W-1:0]     slot_reg, slot_next;
    logic [CH_W-1:0]  cur_reg, cur_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [W-1:0]     cmp_reg [msp_pkg::CHANNELS];

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       lev_reg, lev_next;
    logic [CH_W-1:0]  act_reg;
    logic [W-1:0]     cnt_out_reg;

    logic             cfg_wr;
    logic             acc, out_free, ch_ok, commit;
    logic [CNT_W-1:0] n_eff;
    logic [W-1:0]     c_inc;
    logic [CNT_W-1:0] cur_inc;
    logic [CH_W-1:0]  cur_adv;
    logic             wrap;
    logic             wr_en;
    logic [CH_W-1:0]  wr_ch;
    logic [W-1:0]     wr_val, cmp_cur;

    msp_pkg::ang_req_t  ang_req;
    msp_pkg::ang_cfg_t  ang_cfg;
    msp_pkg::ang_stat_t ang_stat;
    logic [W-1:0]       ang_width;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= msp_pkg::RST_CHANNEL_COUNT;
            reverse_mask_reg  <= msp_pkg::RST_REVERSE_MASK;
            slot_ticks_reg    <= msp_pkg::RST_SLOT_TICKS;
            min_width_reg     <= msp_pkg::RST_MIN_WIDTH;
            max_width_reg     <= msp_pkg::RST_MAX_WIDTH;
            center_width_reg  <= msp_pkg::RST_CENTER_WIDTH;
            min_angle_reg     <= msp_pkg::RST_MIN_ANGLE;
            max_angle_reg     <= msp_pkg::RST_MAX_ANGLE;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                msp_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CNT_W-1:0];
                msp_pkg::REG_REVERSE_MASK:  reverse_mask_reg  <= pwdata[7:0];
                msp_pkg::REG_SLOT_TICKS:    slot_ticks_reg    <= pwdata[W-1:0];
                msp_pkg::REG_MIN_WIDTH:     min_width_reg     <= pwdata[W-1:0];
                msp_pkg::REG_MAX_WIDTH:     max_width_reg     <= pwdata[W-1:0];
                msp_pkg::REG_CENTER_WIDTH:  center_width_reg  <= pwdata[W-1:0];
                msp_pkg::REG_MIN_ANGLE:     min_angle_reg     <= pwdata[W-1:0];
                msp_pkg::REG_MAX_ANGLE:     max_angle_reg     <= pwdata[W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            msp_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, channel_count_reg};
            msp_pkg::REG_REVERSE_MASK:  prdata = {24'd0, reverse_mask_reg};
            msp_pkg::REG_SLOT_TICKS:    prdata = {16'd0, slot_ticks_reg};
            msp_pkg::REG_MIN_WIDTH:     prdata = {16'd0, min_width_reg};
            msp_pkg::REG_MAX_WIDTH:     prdata = {16'd0, max_width_reg};
            msp_pkg::REG_CENTER_WIDTH:  prdata = {16'd0, center_width_reg};
            msp_pkg::REG_MIN_ANGLE:     prdata = {16'd0, min_angle_reg};
            msp_pkg::REG_MAX_ANGLE:     prdata = {16'd0, max_angle_reg};
        endcase
    end

    // angle unit
    assign ang_cfg.min_angle    = min_angle_reg;
    assign ang_cfg.max_angle    = max_angle_reg;
    assign ang_cfg.min_width    = min_width_reg;
    assign ang_cfg.max_width    = max_width_reg;
    assign ang_cfg.center_width = center_width_reg;

    msp_angle_div u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ang_req),
        .cfg     (ang_cfg),
        .stat    (ang_stat),
        .width   (ang_width)
    );

    // request handling
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_valid && s_ready;
    assign n_eff    = msp_pkg::eff_count(channel_count_reg);
    assign ch_ok    = {1'b0, s_channel} < n_eff;

    assign c_inc   = slot_reg + W'(1);
    assign wrap    = (c_inc >= slot_ticks_reg) || (c_inc == '0);
    assign cur_inc = {1'b0, cur_reg} + CNT_W'(1);
    // a stale channel past the count also lands on channel 0
    assign cur_adv = (cur_inc >= n_eff) ? CH_W'(0) : cur_inc[CH_W-1:0];

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        ch_next       = ch_reg;
        wr_en         = 1'b0;
        wr_ch         = s_channel;
        wr_val        = msp_pkg::clamp_width(s_pulse_width, reverse_mask_reg[s_channel],
                                             min_width_reg, max_width_reg);
        commit        = 1'b0;
        ang_req.start = 1'b0;
        ang_req.angle = s_angle;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    unique case (s_req_type)
                        msp_pkg::REQ_TICK: begin
                            slot_next = wrap ? W'(0) : c_inc;
                            cur_next  = wrap ? cur_adv : cur_reg;
                            commit    = 1'b1;
                        end
                        msp_pkg::REQ_WIDTH: begin
                            wr_en  = ch_ok;
                            commit = 1'b1;
                        end
                        msp_pkg::REQ_ANGLE: begin
                            if (ch_ok) begin
                                ang_req.start = 1'b1;
                                ch_next       = s_channel;
                                state_next    = ST_ANGLE;
                            end else begin
                                commit = 1'b1;
                            end
                        end
                        default: begin
                            commit = 1'b1;
                        end
                    endcase
                end
            end
            ST_ANGLE: begin
                if (ang_stat.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_ch  = ch_reg;
                wr_val = msp_pkg::clamp_width(ang_width, reverse_mask_reg[ch_reg],
                                              min_width_reg, max_width_reg);
                if (out_free) begin
                    wr_en      = 1'b1;
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // the word shows the state after the request, so bypass a fresh compare write
    assign cmp_cur  = (wr_en && (wr_ch == cur_next)) ? wr_val : cmp_reg[cur_next];
    assign lev_next = (slot_next >= cmp_cur) ? (8'(1) << cur_next) : 8'd0;
    assign m_valid_next = commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
            lev_reg     <= '0;
            act_reg     <= '0;
            cnt_out_reg <= '0;
            for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
                cmp_reg[i] <= msp_pkg::RST_COMPARE;
            end
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                lev_reg     <= lev_next;
                act_reg     <= cur_next;
                cnt_out_reg <= slot_next;
            end
            if (wr_en) begin
                cmp_reg[wr_ch] <= wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg <= ch_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_pwm_levels     = lev_reg;
    assign m_active_channel = act_reg;
    assign m_slot_count     = cnt_out_reg;

    `MSP_ASSERT_IMP(a_lev_onehot, aclk, aresetn, 1'b1, $onehot0(m_pwm_levels))
    `MSP_ASSERT_IMP(a_lev_active, aclk, aresetn, m_pwm_levels != 8'd0, m_pwm_levels == (8'(1) << m_active_channel))
    `MSP_ASSERT_NXT(a_tick_word, aclk, aresetn, acc && (s_req_type == msp_pkg::REQ_TICK), m_valid)
    `MSP_ASSERT_IMP(a_unit_owned, aclk, aresetn, ang_stat.busy, state_reg == ST_ANGLE)

endmodule

// ===== tb/multiplexed_servo_pwm_core_tb.sv =====
`timescale 1ns / 1ps

module multiplexed_servo_pwm_core_tb;

    localparam logic [1:0] REQ_UNDEF = 2'd3;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 280;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [7:0]  levels;
        logic [2:0]  chan;
        logic [15:0] count;
    } servo_word_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [4:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type    = '0;
    logic [2:0]         s_channel     = '0;
    logic [15:0]        s_pulse_width = '0;
    logic signed [15:0] s_angle       = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [7:0]         m_pwm_levels;
    logic [2:0]         m_active_channel;
    logic [15:0]        m_slot_count;

    multiplexed_servo_pwm_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_channel        (s_channel),
        .s_pulse_width    (s_pulse_width),
        .s_angle          (s_angle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pwm_levels     (m_pwm_levels),
        .m_active_channel (m_active_channel),
        .m_slot_count     (m_slot_count)
    );

    // predictor copy of the registers and state
    logic [3:0]         cfg_count;
    logic [7:0]         cfg_reverse;
    logic [15:0]        cfg_slot_len;
    logic [15:0]        cfg_wmin;
    logic [15:0]        cfg_wmax;
    logic [15:0]        cfg_center;
    logic signed [15:0] cfg_amin;
    logic signed [15:0] cfg_amax;
    logic [15:0]        cmp_val [msp_pkg::CHANNELS];
    logic [15:0]        slot_cnt;
    int                 cur_ch;

    servo_word_t pending_words[$];
    servo_word_t want;
    int          mismatches    = 0;
    int          burst_left    = 0;
    bit          gaps_on       = 1'b1;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          rx_mode       = 0;
    int          mode_left     = 0;
    int          rx_phase      = 0;
    int          stall_cycles  = 0;

    always #2 aclk = ~aclk;

    function automatic int served_count();
        int n;
        n = int'(cfg_count);
        if (n < 1) n = 1;
        if (n > msp_pkg::CHANNELS) n = msp_pkg::CHANNELS;
        return n;
    endfunction

    function automatic logic [15:0] clamped_width(int ch, logic [15:0] t);
        logic [15:0] nt;
        nt = cfg_reverse[ch] ? t : 16'(cfg_wmax + cfg_wmin - t);
        if (nt < cfg_wmin) nt = cfg_wmin;
        if (nt > cfg_wmax) nt = cfg_wmax;
        return nt;
    endfunction

    function automatic logic [15:0] angle_width(logic signed [15:0] ang);
        longint a, lo, hi, span, q;
        a  = ang;
        lo = cfg_amin;
        hi = cfg_amax;
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        span = hi - lo;
        q = 0;
        if (span != 0) q = (a * (longint'(cfg_wmax) - longint'(cfg_wmin))) / span;
        q = q + longint'(cfg_center);
        return q[15:0];
    endfunction

    function automatic servo_word_t servo_step(logic [1:0] req, logic [2:0] ch,
                                               logic [15:0] pw, logic signed [15:0] ang);
        servo_word_t w;
        logic [15:0] c;
        int          n;
        n = served_count();
        case (req)
            msp_pkg::REQ_TICK: begin
                c = slot_cnt + 16'd1;
                // end of slot: wrap and hand over, stale channels fall back to 0
                if (c >= cfg_slot_len || c == 16'd0) begin
                    c = '0;
                    cur_ch = cur_ch + 1;
                    if (cur_ch >= n) cur_ch = 0;
                end
                slot_cnt = c;
            end
            msp_pkg::REQ_WIDTH: if (int'(ch) < n) cmp_val[ch] = clamped_width(ch, pw);
            msp_pkg::REQ_ANGLE:
                if (int'(ch) < n) cmp_val[ch] = clamped_width(ch, angle_width(ang));
            default: ;
        endcase
        w.levels = (slot_cnt >= cmp_val[cur_ch]) ? 8'(1 << cur_ch) : 8'd0;
        w.chan   = 3'(cur_ch);
        w.count  = slot_cnt;
        return w;
    endfunction

    function automatic void reset_predictor();
        cfg_count    = msp_pkg::RST_CHANNEL_COUNT;
        cfg_reverse  = msp_pkg::RST_REVERSE_MASK;
        cfg_slot_len = msp_pkg::RST_SLOT_TICKS;
        cfg_wmin     = msp_pkg::RST_MIN_WIDTH;
        cfg_wmax     = msp_pkg::RST_MAX_WIDTH;
        cfg_center   = msp_pkg::RST_CENTER_WIDTH;
        cfg_amin     = msp_pkg::RST_MIN_ANGLE;
        cfg_amax     = msp_pkg::RST_MAX_ANGLE;
        for (int i = 0; i < msp_pkg::CHANNELS; i++) cmp_val[i] = clamped_width(i, cfg_center);
        slot_cnt = '0;
        cur_ch   = 0;
    endfunction

    function automatic logic [15:0] rand_edge16(int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, hi));
    endfunction

    task automatic report_mismatch(string what, longint got, longint wanted);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, wanted);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // read back right after the write
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            msp_pkg::REG_CHANNEL_COUNT: begin
                cfg_count = value[3:0];     mask = 32'h0000_000F;
            end
            msp_pkg::REG_REVERSE_MASK: begin
                cfg_reverse = value[7:0];   mask = 32'h0000_00FF;
            end
            msp_pkg::REG_SLOT_TICKS: begin
                cfg_slot_len = value[15:0]; mask = 32'h0000_FFFF;
            end
            msp_pkg::REG_MIN_WIDTH: begin
                cfg_wmin = value[15:0];     mask = 32'h0000_FFFF;
            end
            msp_pkg::REG_MAX_WIDTH: begin
                cfg_wmax = value[15:0];     mask = 32'h0000_FFFF;
            end
            msp_pkg::REG_CENTER_WIDTH: begin
                cfg_center = value[15:0];   mask = 32'h0000_FFFF;
            end
            msp_pkg::REG_MIN_ANGLE: begin
                cfg_amin = value[15:0];     mask = 32'h0000_FFFF;
            end
            default: begin
                cfg_amax = value[15:0];     mask = 32'h0000_FFFF;
            end
        endcase
        if ((got & mask) != (value & mask))
            report_mismatch("register readback", got & mask, value & mask);
    endtask

    task automatic send_word(logic [1:0] req, logic [2:0] ch, logic [15:0] pw,
                             logic signed [15:0] ang);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_channel     <= ch;
        s_pulse_width <= pw;
        s_angle       <= ang;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(servo_step(req, ch, pw, ang));
    endtask

    task automatic send_random_word();
        int          r;
        logic [1:0]  req;
        logic [15:0] pw;
        logic [15:0] ang;
        r   = $urandom_range(0, 19);
        req = (r < 10) ? msp_pkg::REQ_TICK : (r < 14) ? msp_pkg::REQ_WIDTH :
              (r < 19) ? msp_pkg::REQ_ANGLE : REQ_UNDEF;
        pw  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60));
        ang = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 800) - 400);
        send_word(req, 3'($urandom_range(0, 7)), pw, ang);
    endtask

    // drop valid and hold until every outstanding word is back
    task automatic drain_words();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_directed_requests();
        send_word(msp_pkg::REQ_TICK,  3'd0, 16'd0,     16'sd0);
        send_word(msp_pkg::REQ_WIDTH, 3'd0, 16'd0,     16'sd0);
        send_word(msp_pkg::REQ_WIDTH, 3'd1, 16'hFFFF,  16'sd0);
        send_word(msp_pkg::REQ_WIDTH, 3'd0, 16'd1500,  16'sd0);
        send_word(msp_pkg::REQ_ANGLE, 3'd0, 16'd0,     16'sh8000);
        send_word(msp_pkg::REQ_ANGLE, 3'd1, 16'd0,     16'sh7FFF);
        send_word(msp_pkg::REQ_ANGLE, 3'd0, 16'd0,     16'sd0);
        send_word(msp_pkg::REQ_ANGLE, 3'd1, 16'd0,     -16'sd45);
        // channels outside the rotation are ignored
        send_word(msp_pkg::REQ_WIDTH, 3'd5, 16'd1000,  16'sd0);
        send_word(msp_pkg::REQ_ANGLE, 3'd7, 16'd0,     16'sd10);
        send_word(REQ_UNDEF,          3'd0, 16'hFFFF,  16'sh7FFF);
        send_word(msp_pkg::REQ_WIDTH, 3'd0, 16'd2400,  16'sd0);
        repeat (5) send_word(msp_pkg::REQ_TICK, 3'd0, 16'd0, 16'sd0);
        drain_words();
    endtask

    task automatic test_register_extremes();
        // one channel, zero slot length, full width range, no reversal
        write_reg(msp_pkg::REG_CHANNEL_COUNT, 32'd0);
        write_reg(msp_pkg::REG_SLOT_TICKS,    32'd0);
        write_reg(msp_pkg::REG_REVERSE_MASK,  32'hFF);
        write_reg(msp_pkg::REG_MIN_WIDTH,     32'd0);
        write_reg(msp_pkg::REG_MAX_WIDTH,     32'hFFFF);
        write_reg(msp_pkg::REG_CENTER_WIDTH,  32'd0);
        write_reg(msp_pkg::REG_MIN_ANGLE,     32'hFFFF_8000);
        write_reg(msp_pkg::REG_MAX_ANGLE,     32'h0000_7FFF);
        send_word(msp_pkg::REQ_WIDTH, 3'd0, 16'd0,    16'sd0);
        repeat (3) send_word(msp_pkg::REQ_TICK, 3'd0, 16'd0, 16'sd0);
        send_word(msp_pkg::REQ_WIDTH, 3'd0, 16'hFFFF, 16'sd0);
        send_word(msp_pkg::REQ_ANGLE, 3'd0, 16'd0,    16'sh8000);
        send_word(msp_pkg::REQ_ANGLE, 3'd0, 16'd0,    16'sh7FFF);
        send_word(msp_pkg::REQ_WIDTH, 3'd1, 16'd7,    16'sd0);
        send_word(msp_pkg::REQ_TICK,  3'd0, 16'd0,    16'sd0);
        drain_words();

        // count above range, min above max, zero angle span
        write_reg(msp_pkg::REG_CHANNEL_COUNT, 32'd15);
        write_reg(msp_pkg::REG_SLOT_TICKS,    32'd1);
        write_reg(msp_pkg::REG_REVERSE_MASK,  32'h00);
        write_reg(msp_pkg::REG_MIN_WIDTH,     32'd2000);
        write_reg(msp_pkg::REG_MAX_WIDTH,     32'd1000);
        write_reg(msp_pkg::REG_CENTER_WIDTH,  32'h8000);
        write_reg(msp_pkg::REG_MIN_ANGLE,     32'd5);
        write_reg(msp_pkg::REG_MAX_ANGLE,     32'd5);
        send_word(msp_pkg::REQ_WIDTH, 3'd7, 16'd0,   16'sd0);
        send_word(msp_pkg::REQ_ANGLE, 3'd6, 16'd0,   -16'sd300);
        repeat (8) send_word(msp_pkg::REQ_TICK, 3'd0, 16'd0, 16'sd0);
        send_word(msp_pkg::REQ_WIDTH, 3'd3, 16'd0,   16'sd0);
        drain_words();

        // inverted angle bounds: the upper bound wins
        write_reg(msp_pkg::REG_CHANNEL_COUNT, 32'd8);
        write_reg(msp_pkg::REG_SLOT_TICKS,    32'hFFFF);
        write_reg(msp_pkg::REG_MIN_WIDTH,     32'd0);
        write_reg(msp_pkg::REG_MAX_WIDTH,     32'hFFFF);
        write_reg(msp_pkg::REG_CENTER_WIDTH,  32'd1000);
        write_reg(msp_pkg::REG_MIN_ANGLE,     32'd100);
        write_reg(msp_pkg::REG_MAX_ANGLE,     32'hFFFF_FF9C);
        send_word(msp_pkg::REQ_ANGLE, 3'd2, 16'd0, 16'sh8000);
        send_word(msp_pkg::REQ_ANGLE, 3'd2, 16'd0, 16'sh7FFF);
        send_word(msp_pkg::REQ_ANGLE, 3'd4, 16'd0, 16'sd0);
        repeat (3) send_word(msp_pkg::REQ_TICK, 3'd0, 16'd0, 16'sd0);
        drain_words();
    endtask

    task automatic test_stale_channel();
        write_reg(msp_pkg::REG_CHANNEL_COUNT, 32'd8);
        write_reg(msp_pkg::REG_SLOT_TICKS,    32'd1);
        while (cur_ch != 7) send_word(msp_pkg::REQ_TICK, 3'd0, 16'd0, 16'sd0);
        drain_words();
        // shrink the rotation under the running channel
        write_reg(msp_pkg::REG_CHANNEL_COUNT, 32'd3);
        send_word(msp_pkg::REQ_WIDTH, 3'd5, 16'd3,  16'sd0);
        send_word(msp_pkg::REQ_TICK,  3'd0, 16'd0,  16'sd0);
        send_word(msp_pkg::REQ_TICK,  3'd0, 16'd0,  16'sd0);
        drain_words();
    endtask

    task automatic test_backpressure();
        write_reg(msp_pkg::REG_CHANNEL_COUNT, 32'd8);
        write_reg(msp_pkg::REG_SLOT_TICKS,    32'd4);
        gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 80; i++)
            send_word((i % 3 == 0) ? msp_pkg::REQ_WIDTH : msp_pkg::REQ_TICK, 3'(i),
                      16'($urandom), 16'sd0);
        drain_words();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int r, lo_a, hi_a;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_words();
            r = $urandom_range(0, 9);
            write_reg(msp_pkg::REG_CHANNEL_COUNT, (r == 0) ? 32'd0 :
                      (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8));
            write_reg(msp_pkg::REG_REVERSE_MASK, $urandom_range(0, 255));
            r = $urandom_range(0, 9);
            write_reg(msp_pkg::REG_SLOT_TICKS, (r == 0) ? 32'd0 : (r == 1) ? 32'd1 :
                      (r == 2) ? 32'hFFFF : $urandom_range(2, 40));
            write_reg(msp_pkg::REG_MIN_WIDTH, rand_edge16(15));
            write_reg(msp_pkg::REG_MAX_WIDTH, 16'(rand_edge16(35) + 16'd10));
            write_reg(msp_pkg::REG_CENTER_WIDTH, rand_edge16(50));
            r = $urandom_range(0, 9);
            if (r == 0) begin
                lo_a = -32768;
                hi_a = 32767;
            end else if (r == 1) begin
                lo_a = $urandom_range(0, 600) - 300;
                hi_a = lo_a;
            end else if (r == 2) begin
                lo_a = $urandom_range(0, 300);
                hi_a = -$urandom_range(0, 300);
            end else begin
                lo_a = -$urandom_range(0, 300);
                hi_a = $urandom_range(0, 300);
            end
            write_reg(msp_pkg::REG_MIN_ANGLE, 32'(lo_a));
            write_reg(msp_pkg::REG_MAX_ANGLE, 32'(hi_a));
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_WORDS) send_random_word();
        end
        gaps_on = 1'b1;
    endtask

    // result side: pick a stall pattern now and then, honor long hold requests
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
        end else begin
            mode_left--;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (rx_phase % 3 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing expected", m_slot_count, 0);
            end else begin
                want = pending_words.pop_front();
                if (m_pwm_levels !== want.levels)
                    report_mismatch("pwm_levels", m_pwm_levels, want.levels);
                if (m_active_channel !== want.chan)
                    report_mismatch("active_channel", m_active_channel, want.chan);
                if (m_slot_count !== want.count)
                    report_mismatch("slot_count", m_slot_count, want.count);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_requests();
        test_register_extremes();
        test_stale_channel();
        test_backpressure();
        test_random_traffic();
        drain_words();
        repeat (64) @(posedge aclk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
